[rtl/taf_pkg.sv]
// taf_pkg: shared types, constants and command codes of the target attraction force block
// used by taf_ctrl, taf_dpath and target_attraction_force_top; depends on nothing

package taf_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int SCALE_W   = FRAC_BITS + 1;
   localparam int AMP_SUM_W = 31 + FRAC_BITS + 1;
   localparam logic [SCALE_W-1:0] ONE = SCALE_W'(1) << FRAC_BITS;

   // register reset values
   localparam logic [30:0] MIN_DIST_RST = 31'd6554;
   localparam logic [30:0] MAX_DIST_RST = 31'd655360;
   localparam logic [30:0] MIN_AMP_RST  = 31'd0;
   localparam logic [30:0] MAX_AMP_RST  = 31'd655360;
   localparam logic [15:0] INTERVAL_RST = 16'd1;

   // iteration counts of the shared shift-subtract unit
   localparam logic [5:0] ROOT_STEPS  = 6'd32;
   localparam logic [5:0] SCALE_STEPS = 6'(FRAC_BITS);
   localparam logic [5:0] FORCE_STEPS = 6'd31;

   typedef enum logic [2:0] {
      CSR_TARGET_X = 3'd0,
      CSR_TARGET_Y = 3'd1,
      CSR_TARGET_Z = 3'd2,
      CSR_MIN_DIST = 3'd3,
      CSR_MAX_DIST = 3'd4,
      CSR_MIN_AMP  = 3'd5,
      CSR_MAX_AMP  = 3'd6,
      CSR_INTERVAL = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_SQ_M0,
      CMD_SQ_M1,
      CMD_SQ_M2,
      CMD_SQ_MAX,
      CMD_SQ_MIN,
      CMD_TEST,
      CMD_ROOT_INIT,
      CMD_ITER,
      CMD_DIST,
      CMD_SCALE_INIT,
      CMD_SCALE,
      CMD_AMP_HI,
      CMD_AMP_LO,
      CMD_AMP,
      CMD_FMUL,
      CMD_FDIV_INIT,
      CMD_FSTORE,
      CMD_PUBLISH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic bound_ok;
      logic iter_done;
   } status_type;

endpackage

[rtl/taf_ctrl.sv]
// taf_ctrl: sequencer of the target attraction force block
// drives taf_dpath through taf_pkg::cmd_type and reads taf_pkg::status_type

module taf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  taf_pkg::status_type  status,
   output taf_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_SQ_M0, S_SQ_M1, S_SQ_M2, S_SQ_MAX, S_SQ_MIN, S_TEST,
      S_ROOT_INIT, S_ROOT_RUN, S_DIST, S_SCALE_INIT, S_SCALE_RUN, S_SCALE,
      S_AMP_HI, S_AMP_LO, S_AMP, S_FMUL, S_FDIV_INIT, S_FDIV_RUN, S_FSTORE, S_PUBLISH
   } state_type;

   state_type  state_ff;
   logic [1:0] axis_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.axis = axis_ff;
      cmd.op   = taf_pkg::CMD_NOP;
      unique case (state_ff) inside
         S_IDLE:       if (req_valid) cmd.op = taf_pkg::CMD_LOAD;
         S_CHECK:      cmd.op = taf_pkg::CMD_NOP;
         S_SQ_M0:      cmd.op = taf_pkg::CMD_SQ_M0;
         S_SQ_M1:      cmd.op = taf_pkg::CMD_SQ_M1;
         S_SQ_M2:      cmd.op = taf_pkg::CMD_SQ_M2;
         S_SQ_MAX:     cmd.op = taf_pkg::CMD_SQ_MAX;
         S_SQ_MIN:     cmd.op = taf_pkg::CMD_SQ_MIN;
         S_TEST:       cmd.op = taf_pkg::CMD_TEST;
         S_ROOT_INIT:  cmd.op = taf_pkg::CMD_ROOT_INIT;
         S_ROOT_RUN,
         S_SCALE_RUN,
         S_FDIV_RUN:   if (!status.iter_done) cmd.op = taf_pkg::CMD_ITER;
         S_DIST:       cmd.op = taf_pkg::CMD_DIST;
         S_SCALE_INIT: cmd.op = taf_pkg::CMD_SCALE_INIT;
         S_SCALE:      cmd.op = taf_pkg::CMD_SCALE;
         S_AMP_HI:     cmd.op = taf_pkg::CMD_AMP_HI;
         S_AMP_LO:     cmd.op = taf_pkg::CMD_AMP_LO;
         S_AMP:        cmd.op = taf_pkg::CMD_AMP;
         S_FMUL:       cmd.op = taf_pkg::CMD_FMUL;
         S_FDIV_INIT:  cmd.op = taf_pkg::CMD_FDIV_INIT;
         S_FSTORE:     cmd.op = taf_pkg::CMD_FSTORE;
         S_PUBLISH:    if (out_free) cmd.op = taf_pkg::CMD_PUBLISH;
         default:      cmd.op = taf_pkg::CMD_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // new result on publish, otherwise held only while stalled
         rsp_valid_ff <= (state_ff == S_PUBLISH && out_free) || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE:       if (req_valid) state_ff <= S_CHECK;
            S_CHECK:      state_ff <= status.range_ok ? S_SQ_M0 : S_PUBLISH;
            S_SQ_M0:      state_ff <= S_SQ_M1;
            S_SQ_M1:      state_ff <= S_SQ_M2;
            S_SQ_M2:      state_ff <= S_SQ_MAX;
            S_SQ_MAX:     state_ff <= S_SQ_MIN;
            S_SQ_MIN:     state_ff <= S_TEST;
            S_TEST:       state_ff <= status.bound_ok ? S_ROOT_INIT : S_PUBLISH;
            S_ROOT_INIT:  state_ff <= S_ROOT_RUN;
            S_ROOT_RUN:   if (status.iter_done) state_ff <= S_DIST;
            S_DIST:       state_ff <= S_SCALE_INIT;
            S_SCALE_INIT: state_ff <= S_SCALE_RUN;
            S_SCALE_RUN:  if (status.iter_done) state_ff <= S_SCALE;
            S_SCALE:      state_ff <= S_AMP_HI;
            S_AMP_HI:     state_ff <= S_AMP_LO;
            S_AMP_LO:     state_ff <= S_AMP;
            S_AMP: begin
               axis_ff  <= 2'd0;
               state_ff <= S_FMUL;
            end
            S_FMUL:       state_ff <= S_FDIV_INIT;
            S_FDIV_INIT:  state_ff <= S_FDIV_RUN;
            S_FDIV_RUN:   if (status.iter_done) state_ff <= S_FSTORE;
            S_FSTORE: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= S_PUBLISH;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_FMUL;
               end
            end
            S_PUBLISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:      state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/taf_dpath.sv]
// taf_dpath: registers, gate, multiplier and shared shift-subtract unit
// depends on taf_pkg; commanded by taf_ctrl

module taf_dpath (
   input  logic                clock,
   input  logic                reset,
   input  taf_pkg::cmd_type    cmd,
   output taf_pkg::status_type status,
   input  logic                req_first_in_update,
   input  logic                req_behaviour_active,
   input  logic [47:0]         req_time_ms,
   input  logic [15:0]         req_part_id,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic [15:0]         rsp_out_part_id,
   output logic                rsp_applied,
   output logic signed [31:0]  rsp_force_x,
   output logic signed [31:0]  rsp_force_y,
   output logic signed [31:0]  rsp_force_z
);

   // configuration
   logic signed [31:0] tgt_ff [3];
   logic [30:0] min_dist_ff, max_dist_ff, min_amp_ff, max_amp_ff;
   logic [15:0] interval_ff;

   // gate state
   logic [47:0] last_time_ff;
   logic        gate_ff;
   logic [48:0] thresh;
   logic        gate_open;

   // item
   logic [15:0]        part_id_ff;
   logic signed [32:0] d_ff [3];
   logic [32:0]        mag [3];

   // arithmetic
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] mul_ff, sum_ff;
   logic        hi_ok_ff;
   logic [30:0] dist_ff, amp_ff;
   logic [taf_pkg::SCALE_W-1:0]   scale_ff, one_minus;
   logic [taf_pkg::AMP_SUM_W-1:0] amp_t_ff, amp_sum;
   logic        applied_ff;
   logic signed [31:0] force_ff [3];
   logic [31:0] quot;

   // shared shift-subtract unit: square root (two bits per step) or division (one bit)
   logic        mode_root_ff;
   logic [34:0] rem_ff, shifted, trial;
   logic [31:0] acc_ff;
   logic [63:0] src_ff;
   logic [5:0]  cnt_ff;
   logic [30:0] div_ff;
   logic        ge;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = d_ff[k][32] ? 33'(-d_ff[k]) : 33'(d_ff[k]);
      end
   end

   assign thresh    = {1'b0, last_time_ff} + 49'(interval_ff);
   assign gate_open = req_behaviour_active && ({1'b0, req_time_ms} > thresh);

   assign status.range_ok = gate_ff && (mag[0] <= {2'b00, max_dist_ff})
                            && (mag[1] <= {2'b00, max_dist_ff})
                            && (mag[2] <= {2'b00, max_dist_ff});
   assign status.bound_ok  = hi_ok_ff && (sum_ff >= mul_ff) && (sum_ff != 64'd0);
   assign status.iter_done = (cnt_ff == 6'd0);

   assign one_minus = taf_pkg::ONE - scale_ff;
   assign amp_sum   = amp_t_ff + mul_ff[taf_pkg::AMP_SUM_W-1:0];

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (cmd.op)
         taf_pkg::CMD_SQ_M0: begin
            mul_a = {1'b0, mag[0][30:0]};
            mul_b = {1'b0, mag[0][30:0]};
         end
         taf_pkg::CMD_SQ_M1: begin
            mul_a = {1'b0, mag[1][30:0]};
            mul_b = {1'b0, mag[1][30:0]};
         end
         taf_pkg::CMD_SQ_M2: begin
            mul_a = {1'b0, mag[2][30:0]};
            mul_b = {1'b0, mag[2][30:0]};
         end
         taf_pkg::CMD_SQ_MAX: begin
            mul_a = {1'b0, max_dist_ff};
            mul_b = {1'b0, max_dist_ff};
         end
         taf_pkg::CMD_SQ_MIN: begin
            mul_a = {1'b0, min_dist_ff};
            mul_b = {1'b0, min_dist_ff};
         end
         taf_pkg::CMD_AMP_HI: begin
            mul_a = {1'b0, max_amp_ff};
            mul_b = 32'(scale_ff);
         end
         taf_pkg::CMD_AMP_LO: begin
            mul_a = {1'b0, min_amp_ff};
            mul_b = 32'(one_minus);
         end
         taf_pkg::CMD_FMUL: begin
            mul_a = {1'b0, mag[cmd.axis][30:0]};
            mul_b = {1'b0, amp_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign shifted = mode_root_ff ? {rem_ff[32:0], src_ff[63:62]}
                                 : {2'b00, rem_ff[31:0], src_ff[63]};
   assign trial   = mode_root_ff ? {1'b0, acc_ff, 2'b01} : {4'b0000, div_ff};
   assign ge      = (shifted >= trial);

   // quotient never exceeds amp because each axis magnitude is at most the distance
   assign quot = {1'b0, acc_ff[30:0]};

   // configuration and gate
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff[0]    <= 32'sd0;
         tgt_ff[1]    <= 32'sd0;
         tgt_ff[2]    <= 32'sd0;
         min_dist_ff  <= taf_pkg::MIN_DIST_RST;
         max_dist_ff  <= taf_pkg::MAX_DIST_RST;
         min_amp_ff   <= taf_pkg::MIN_AMP_RST;
         max_amp_ff   <= taf_pkg::MAX_AMP_RST;
         interval_ff  <= taf_pkg::INTERVAL_RST;
         last_time_ff <= 48'd0;
         gate_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               taf_pkg::CSR_TARGET_X: tgt_ff[0]   <= csr_wdata;
               taf_pkg::CSR_TARGET_Y: tgt_ff[1]   <= csr_wdata;
               taf_pkg::CSR_TARGET_Z: tgt_ff[2]   <= csr_wdata;
               taf_pkg::CSR_MIN_DIST: min_dist_ff <= csr_wdata[30:0];
               taf_pkg::CSR_MAX_DIST: max_dist_ff <= csr_wdata[30:0];
               taf_pkg::CSR_MIN_AMP:  min_amp_ff  <= csr_wdata[30:0];
               taf_pkg::CSR_MAX_AMP:  max_amp_ff  <= csr_wdata[30:0];
               taf_pkg::CSR_INTERVAL: interval_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.op == taf_pkg::CMD_LOAD && req_first_in_update) begin
            gate_ff <= gate_open;
            if (gate_open) last_time_ff <= req_time_ms;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      mul_ff <= prod;
      case (cmd.op) inside
         taf_pkg::CMD_LOAD: begin
            part_id_ff  <= req_part_id;
            d_ff[0]     <= 33'(tgt_ff[0]) - 33'(req_pos_x);
            d_ff[1]     <= 33'(tgt_ff[1]) - 33'(req_pos_y);
            d_ff[2]     <= 33'(tgt_ff[2]) - 33'(req_pos_z);
            applied_ff  <= 1'b0;
            force_ff[0] <= 32'sd0;
            force_ff[1] <= 32'sd0;
            force_ff[2] <= 32'sd0;
         end
         taf_pkg::CMD_SQ_M1:  sum_ff <= mul_ff;
         taf_pkg::CMD_SQ_M2,
         taf_pkg::CMD_SQ_MAX: sum_ff <= sum_ff + mul_ff;
         taf_pkg::CMD_SQ_MIN: hi_ok_ff <= (sum_ff <= mul_ff);
         taf_pkg::CMD_TEST:   applied_ff <= status.bound_ok;
         taf_pkg::CMD_ROOT_INIT: begin
            mode_root_ff <= 1'b1;
            rem_ff       <= 35'd0;
            acc_ff       <= 32'd0;
            src_ff       <= sum_ff;
            cnt_ff       <= taf_pkg::ROOT_STEPS;
         end
         taf_pkg::CMD_ITER: begin
            rem_ff <= ge ? (shifted - trial) : shifted;
            acc_ff <= {acc_ff[30:0], ge};
            src_ff <= mode_root_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
         end
         taf_pkg::CMD_DIST:   dist_ff <= acc_ff[30:0];
         taf_pkg::CMD_SCALE_INIT: begin
            // remainder starts at dist, below max_dist unless the two are equal
            mode_root_ff <= 1'b0;
            rem_ff       <= {4'b0000, dist_ff};
            acc_ff       <= 32'd0;
            src_ff       <= 64'd0;
            div_ff       <= max_dist_ff;
            cnt_ff       <= taf_pkg::SCALE_STEPS;
         end
         taf_pkg::CMD_SCALE: begin
            if (dist_ff == max_dist_ff) scale_ff <= '0;
            else scale_ff <= taf_pkg::ONE - {1'b0, acc_ff[taf_pkg::FRAC_BITS-1:0]};
         end
         taf_pkg::CMD_AMP_LO: amp_t_ff <= mul_ff[taf_pkg::AMP_SUM_W-1:0];
         taf_pkg::CMD_AMP:    amp_ff <= amp_sum[taf_pkg::FRAC_BITS+30:taf_pkg::FRAC_BITS];
         taf_pkg::CMD_FDIV_INIT: begin
            mode_root_ff <= 1'b0;
            rem_ff       <= {4'b0000, mul_ff[61:31]};
            acc_ff       <= 32'd0;
            src_ff       <= {mul_ff[30:0], 33'd0};
            div_ff       <= dist_ff;
            cnt_ff       <= taf_pkg::FORCE_STEPS;
         end
         taf_pkg::CMD_FSTORE: begin
            force_ff[cmd.axis] <= d_ff[cmd.axis][32] ? -quot : quot;
         end
         taf_pkg::CMD_PUBLISH: begin
            rsp_out_part_id <= part_id_ff;
            rsp_applied     <= applied_ff;
            rsp_force_x     <= force_ff[0];
            rsp_force_y     <= force_ff[1];
            rsp_force_z     <= force_ff[2];
         end
         default: ;
      endcase
   end

endmodule

[rtl/target_attraction_force_top.sv]
// target_attraction_force_top: top level of the target attraction force block
// instantiates taf_ctrl and taf_dpath; uses taf_pkg
//
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  first_in_update, behaviour_active, time_ms,
//                                             part_id, pos_x, pos_y, pos_z
// rsp_      out        rsp_valid / rsp_stall  out_part_id, applied, force_x/y/z
// csr_      in         csr_we                 csr_index, csr_wdata
//
// sequence: one transaction at a time; a shut gate or a part out of range goes straight to
// publish, as do failing sum-of-squares bounds, and an applied force runs the square root,
// the scale division and, per axis, a multiply and a 31-step division, all on the one
// shared shift-subtract unit
// reset: synchronous, clears configuration to defaults, gate shut, last time zero
// stalls: the finished result sits in an output register, so the next transaction is
// taken while rsp_stall holds the previous one; only its final publish step waits

module target_attraction_force_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_in_update,
   input  logic               req_behaviour_active,
   input  logic [47:0]        req_time_ms,
   input  logic [15:0]        req_part_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_part_id,
   output logic               rsp_applied,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // command and status between sequencer and datapath
   taf_pkg::cmd_type    cmd;
   taf_pkg::status_type status;

   taf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   taf_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_first_in_update  (req_first_in_update),
      .req_behaviour_active (req_behaviour_active),
      .req_time_ms          (req_time_ms),
      .req_part_id          (req_part_id),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_out_part_id      (rsp_out_part_id),
      .rsp_applied          (rsp_applied),
      .rsp_force_x          (rsp_force_x),
      .rsp_force_y          (rsp_force_y),
      .rsp_force_z          (rsp_force_z)
   );

`ifndef SYNTHESIS
   // an accepted transaction keeps the input side busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // a part without force reports zero on every axis
   a_zero_when_not_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_applied) |->
         (rsp_force_x == 32'sd0 && rsp_force_y == 32'sd0 && rsp_force_z == 32'sd0))
      else $error("force nonzero without application");

   // the shared unit is never stepped past its last iteration
   a_iter_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == taf_pkg::CMD_ITER) |-> !status.iter_done)
      else $error("shift-subtract unit stepped when done");
`endif

endmodule

[sim/target_attraction_force_top_tb.sv]
// target_attraction_force_top_tb: self-checking testbench of the target attraction force block
// drives random and directed transactions, predicts each result, compares field by field
// depends on taf_pkg and target_attraction_force_top

module target_attraction_force_top_tb;

   typedef struct {
      logic               first;
      logic               active;
      logic [47:0]        now;
      logic [15:0]        part;
      logic signed [31:0] px, py, pz;
   } part_txn_type;

   typedef struct {
      logic [15:0]        part;
      logic               applied;
      logic signed [31:0] fx, fy, fz;
   } force_txn_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // dut ports
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_first_in_update = 1'b0;
   logic               req_behaviour_active = 1'b0;
   logic [47:0]        req_time_ms = '0;
   logic [15:0]        req_part_id = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_out_part_id;
   logic               rsp_applied;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   target_attraction_force_top uut (.*);

   // predictor copy of the configuration and state
   logic signed [31:0] tgt_x, tgt_y, tgt_z;
   logic [30:0]        lim_min_dist, lim_max_dist, amp_at_max, amp_at_zero;
   logic [15:0]        gap_ms;
   logic [47:0]        last_applied_ms;
   logic               gate_is_open;

   part_txn_type  pending_parts[$];
   force_txn_type expected_forces[$];
   int            failures = 0;
   int            sent = 0;
   bit            quiet = 1'b0;   // no idling in the last part of the run

   // stall seen at the rising edge, so the driver knows what was accepted
   logic req_stall_q = 1'b0;
   int   watchdog = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clamp_force(logic [63:0] m, bit neg);
      if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
      return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
   endfunction

   // force on one part, updating the gate on the first part of a pass
   function automatic force_txn_type attraction_force(part_txn_type t);
      force_txn_type r;
      logic signed [33:0] dv[3];
      logic [63:0] mg[3];
      logic [63:0] s, root_len, q, scale, amp, one;
      r.part = t.part; r.applied = 0; r.fx = 0; r.fy = 0; r.fz = 0;
      if (t.first) begin
         if (t.active && {1'b0, t.now} > {1'b0, last_applied_ms} + gap_ms) begin
            gate_is_open    = 1'b1;
            last_applied_ms = t.now;
         end else begin
            gate_is_open = 1'b0;
         end
      end
      dv[0] = tgt_x - t.px;
      dv[1] = tgt_y - t.py;
      dv[2] = tgt_z - t.pz;
      for (int i = 0; i < 3; i++) mg[i] = dv[i] < 0 ? 64'(-dv[i]) : 64'(dv[i]);
      if (gate_is_open && mg[0] <= lim_max_dist && mg[1] <= lim_max_dist
          && mg[2] <= lim_max_dist) begin
         s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
         if (s <= 64'(lim_max_dist) * lim_max_dist && s >= 64'(lim_min_dist) * lim_min_dist
             && s != 0) begin
            one      = 64'd1 << taf_pkg::FRAC_BITS;
            root_len = int_sqrt(s);
            q        = (root_len << taf_pkg::FRAC_BITS) / lim_max_dist;
            scale    = q >= one ? 0 : one - q;
            amp      = (64'(amp_at_zero) * scale + 64'(amp_at_max) * (one - scale))
                       >> taf_pkg::FRAC_BITS;
            r.fx = clamp_force((mg[0] * amp) / root_len, dv[0] < 0);
            r.fy = clamp_force((mg[1] * amp) / root_len, dv[1] < 0);
            r.fz = clamp_force((mg[2] * amp) / root_len, dv[2] < 0);
            r.applied = 1;
         end
      end
      return r;
   endfunction

   // driver: presents queued transactions, random idle bursts between them
   int req_idle = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            // the transaction was taken at the last rising edge
            if (pending_parts.size() > 0 && req_idle == 0 &&
                (quiet || $urandom_range(0, 5) != 0)) begin
               load_part(pending_parts.pop_front());
            end else begin
               req_valid <= 1'b0;
               if (!quiet && req_idle == 0) req_idle = $urandom_range(1, 13);
            end
         end else if (!req_valid) begin
            if (req_idle > 0) req_idle--;
            else if (pending_parts.size() > 0) load_part(pending_parts.pop_front());
         end
      end
   end

   task automatic load_part(part_txn_type t);
      req_valid            <= 1'b1;
      req_first_in_update  <= t.first;
      req_behaviour_active <= t.active;
      req_time_ms          <= t.now;
      req_part_id          <= t.part;
      req_pos_x            <= t.px;
      req_pos_y            <= t.py;
      req_pos_z            <= t.pz;
   endtask

   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_forces.push_back(attraction_force('{req_first_in_update,
            req_behaviour_active, req_time_ms, req_part_id, req_pos_x, req_pos_y,
            req_pos_z}));
         sent++;
      end
   end

   // receiver stall bursts
   int rsp_idle = 0;
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_idle > 0) begin
         rsp_idle--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_idle = $urandom_range(1, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      force_txn_type e;
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_forces.size() == 0) begin
            $display("%0t: unexpected result part %0d", $time, rsp_out_part_id);
            failures++;
         end else begin
            e = expected_forces.pop_front();
            if (rsp_out_part_id !== e.part) begin
               $display("%0t: part_id expected %0d actual %0d", $time, e.part, rsp_out_part_id);
               failures++;
            end
            if (rsp_applied !== e.applied) begin
               $display("%0t: applied expected %0d actual %0d", $time, e.applied, rsp_applied);
               failures++;
            end
            if (rsp_force_x !== e.fx) begin
               $display("%0t: force_x expected %0d actual %0d", $time, e.fx, rsp_force_x);
               failures++;
            end
            if (rsp_force_y !== e.fy) begin
               $display("%0t: force_y expected %0d actual %0d", $time, e.fy, rsp_force_y);
               failures++;
            end
            if (rsp_force_z !== e.fz) begin
               $display("%0t: force_z expected %0d actual %0d", $time, e.fz, rsp_force_z);
               failures++;
            end
         end
      end
   end

   // watchdog: no transaction for a long time means the block hung
   always @(posedge clock) begin
      if (watchdog > 5000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // register write at the falling edge, mirrored into the predictor
   task automatic write_csr(taf_pkg::csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         taf_pkg::CSR_TARGET_X: tgt_x = val;
         taf_pkg::CSR_TARGET_Y: tgt_y = val;
         taf_pkg::CSR_TARGET_Z: tgt_z = val;
         taf_pkg::CSR_MIN_DIST: lim_min_dist = val[30:0];
         taf_pkg::CSR_MAX_DIST: lim_max_dist = val[30:0];
         taf_pkg::CSR_MIN_AMP:  amp_at_max = val[30:0];
         taf_pkg::CSR_MAX_AMP:  amp_at_zero = val[30:0];
         taf_pkg::CSR_INTERVAL: gap_ms = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_parts.size() > 0 || req_valid || expected_forces.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic queue_part(bit first, bit active, logic [47:0] now, logic [15:0] part,
                             logic signed [31:0] px, py, pz);
      pending_parts.push_back('{first, active, now, part, px, py, pz});
   endtask

   // position near the target so that many parts fall inside the bounds
   function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
      return c + $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // a pass: first part then a few more, with random content
   logic [47:0] clock_ms = 48'd10;
   task automatic queue_pass(int span);
      int n;
      n = $urandom_range(1, 6);
      clock_ms += $urandom_range(0, 3) == 0 ? 48'd0 : 48'($urandom_range(0, 40));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            queue_part(k == 0, $urandom_range(0, 7) != 0, 48'({$urandom, $urandom}),
                       16'($urandom), $urandom, $urandom, $urandom);
         else
            queue_part(k == 0, $urandom_range(0, 7) != 0, clock_ms, 16'($urandom),
                       near(tgt_x, span), near(tgt_y, span), near(tgt_z, span));
      end
   endtask

   initial begin
      tgt_x = 0; tgt_y = 0; tgt_z = 0;
      lim_min_dist = taf_pkg::MIN_DIST_RST; lim_max_dist = taf_pkg::MAX_DIST_RST;
      amp_at_max = taf_pkg::MIN_AMP_RST; amp_at_zero = taf_pkg::MAX_AMP_RST;
      gap_ms = taf_pkg::INTERVAL_RST;
      last_applied_ms = 0; gate_is_open = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: parts before any first item, extremes, zero distance, inactive
      queue_part(1'b0, 1'b1, 48'd5, 16'd0, 32'sd0, 32'sd0, 32'sd100000);
      queue_part(1'b1, 1'b0, 48'd50, 16'hFFFF, 32'sd65536, 0, 0);
      queue_part(1'b0, 1'b1, 48'd50, 16'd1, 32'sd65536, 0, 0);
      queue_part(1'b1, 1'b1, 48'd100, 16'd2, 32'sd65536, 0, 0);
      queue_part(1'b0, 1'b0, 48'd100, 16'd3, 0, 0, 0);
      queue_part(1'b0, 1'b0, 48'd100, 16'd4, 32'sd2000, 0, 0);
      queue_part(1'b0, 1'b0, 48'd100, 16'd5, -32'sd655360, 0, 0);
      queue_part(1'b0, 1'b0, 48'd100, 16'd6, -32'sd655361, 0, 0);
      queue_part(1'b0, 1'b0, 48'd100, 16'd7, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000);
      queue_part(1'b1, 1'b1, 48'd101, 16'd8, 32'sd100000, -32'sd100000, 32'sd100000);
      queue_part(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 16'd9, 32'sd300000, 32'sd300000,
                 -32'sd300000);
      queue_part(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 16'd10, 32'sd1, 32'sd1, 32'sd1);
      wait_idle();

      // phases with different settings, extremes among them
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(taf_pkg::CSR_TARGET_X, 32'h7FFF_FFFF);
               write_csr(taf_pkg::CSR_TARGET_Y, 32'h8000_0000);
               write_csr(taf_pkg::CSR_TARGET_Z, 0);
               write_csr(taf_pkg::CSR_MIN_DIST, 0);
               write_csr(taf_pkg::CSR_MAX_DIST, 32'h7FFF_FFFF);
               write_csr(taf_pkg::CSR_MIN_AMP, 32'h7FFF_FFFF);
               write_csr(taf_pkg::CSR_MAX_AMP, 32'h7FFF_FFFF);
               write_csr(taf_pkg::CSR_INTERVAL, 0);
            end
            1: begin
               write_csr(taf_pkg::CSR_TARGET_X, $urandom);
               write_csr(taf_pkg::CSR_TARGET_Y, $urandom);
               write_csr(taf_pkg::CSR_TARGET_Z, $urandom);
               write_csr(taf_pkg::CSR_MIN_DIST, 32'd100);
               write_csr(taf_pkg::CSR_MAX_DIST, 32'd1000000);
               write_csr(taf_pkg::CSR_MIN_AMP, 32'd1000);
               write_csr(taf_pkg::CSR_MAX_AMP, 32'd5000000);
               write_csr(taf_pkg::CSR_INTERVAL, 32'h0000_FFFF);
            end
            2: begin
               write_csr(taf_pkg::CSR_MIN_DIST, 32'd500000);
               write_csr(taf_pkg::CSR_MAX_DIST, 32'd1000);
               write_csr(taf_pkg::CSR_INTERVAL, 3);
            end
            3: begin
               write_csr(taf_pkg::CSR_MIN_DIST, 0);
               write_csr(taf_pkg::CSR_MAX_DIST, 0);
            end
            4: begin
               write_csr(taf_pkg::CSR_MAX_DIST, 32'd1);
               write_csr(taf_pkg::CSR_MAX_AMP, 0);
               write_csr(taf_pkg::CSR_MIN_AMP, 32'h7FFF_FFFF);
            end
            default: begin
               write_csr(taf_pkg::CSR_TARGET_X, $urandom);
               write_csr(taf_pkg::CSR_TARGET_Y, $urandom);
               write_csr(taf_pkg::CSR_TARGET_Z, $urandom);
               write_csr(taf_pkg::CSR_MIN_DIST, $urandom_range(0, 50000));
               write_csr(taf_pkg::CSR_MAX_DIST, $urandom_range(100000, 32'h7FFF_FFFF));
               write_csr(taf_pkg::CSR_MIN_AMP, $urandom_range(0, 32'h7FFF_FFFF));
               write_csr(taf_pkg::CSR_MAX_AMP, $urandom_range(0, 32'h7FFF_FFFF));
               write_csr(taf_pkg::CSR_INTERVAL, $urandom_range(0, 20));
            end
         endcase
         if (ph == 7) quiet = 1'b1;
         while (pending_parts.size() < 50)
            queue_pass(ph == 0 ? 32'h7FFF_FFFF : (ph <= 4 ? 2000000 : lim_max_dist));
         wait_idle();
      end

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
